// File: rtl/hsis_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hash set package
// Shared constants for the chained hash set: key width, request codes,
// default table geometry and the shape of the bucket remainder unit.
// ----------------------------------------------------------------------------
package hsis_pkg;

  // Key width of one request.
  localparam int KEY_W = 31;

  // Request codes.
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // Default table geometry.
  localparam int BUCKETS_DEF          = 23;
  localparam int SLOTS_PER_BUCKET_DEF = 8;

  // The remainder unit consumes MOD_DIGIT key bits per cycle.
  localparam int MOD_DIGIT = 8;
  localparam int MOD_CYC   = (KEY_W + MOD_DIGIT - 1) / MOD_DIGIT;
  localparam int MOD_W     = MOD_CYC * MOD_DIGIT;
  localparam int MOD_CNT_W = (MOD_CYC > 1) ? $clog2(MOD_CYC) : 1;

endpackage

// File: rtl/hash_set_insert_search_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chained hash set with insert and search
// Keys are kept in a slot memory, SLOTS_PER_BUCKET slots per bucket, with a
// per-bucket fill count in a second memory. The bucket is key mod BUCKETS.
// ----------------------------------------------------------------------------
// Each request returns one result. The bucket remainder is formed MOD_DIGIT
// key bits per cycle, then the fill count is read from its memory. An insert
// then writes its key and the raised fill count; a search reads the bucket's
// filled slots from the slot memory one per cycle and stops early on a hit.
// One request is in work at a time; a new one is taken while the previous
// result still waits at the output. After reset the fill memory is cleared
// one bucket per cycle, and no request is taken until it is done. Inserts do
// not check for duplicates; an insert into a full bucket is refused and
// flagged with bucket_full.
// ----------------------------------------------------------------------------
module hash_set_insert_search_top #(
  parameter int BUCKETS          = hsis_pkg::BUCKETS_DEF,
  parameter int SLOTS_PER_BUCKET = hsis_pkg::SLOTS_PER_BUCKET_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_opcode,
  input  logic [hsis_pkg::KEY_W-1:0] in_key_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_found,
  output logic                       out_bucket_full
);

  localparam int BW      = $clog2(BUCKETS);
  localparam int DEPTH   = BUCKETS * SLOTS_PER_BUCKET;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW      = $clog2(SLOTS_PER_BUCKET + 1);
  localparam logic [BW:0]   BUCKETS_X = (BW + 1)'(BUCKETS);
  localparam logic [BW-1:0] LAST_BKT  = BW'(BUCKETS - 1);
  localparam logic [AW-1:0] SLOTS_A   = AW'(SLOTS_PER_BUCKET);
  localparam logic [FW-1:0] SLOTS_F   = FW'(SLOTS_PER_BUCKET);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_FILL_RD,
    ST_DECIDE,
    ST_SCAN,
    ST_RESULT
  } state_t;

  // Storage.
  logic [hsis_pkg::KEY_W-1:0] slot_mem [DEPTH];
  logic [FW-1:0]              fill_mem [BUCKETS];

  // Registers.
  state_t                         state_r, state_nxt;
  logic [BW-1:0]                  clr_cnt_r, clr_cnt_nxt;
  logic                           op_r, op_nxt;
  logic [hsis_pkg::KEY_W-1:0]     key_r, key_nxt;
  logic [hsis_pkg::MOD_W-1:0]     mod_sh_r, mod_sh_nxt;
  logic [hsis_pkg::MOD_CNT_W-1:0] mod_cnt_r, mod_cnt_nxt;
  logic [BW-1:0]                  rem_r, rem_nxt;
  logic [AW-1:0]                  base_r, base_nxt;
  logic [FW-1:0]                  scan_idx_r, scan_idx_nxt;
  logic                           cmp_valid_r, cmp_valid_nxt;
  logic                           res_found_r, res_found_nxt;
  logic                           res_full_r, res_full_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic                           out_found_r, out_found_nxt;
  logic                           out_full_r, out_full_nxt;

  // Memory read data registers.
  logic [FW-1:0]              fill_q_r;
  logic [hsis_pkg::KEY_W-1:0] slot_q_r;

  // Memory control.
  logic                       fill_re;
  logic                       fill_we;
  logic [BW-1:0]              fill_wa;
  logic [FW-1:0]              fill_wd;
  logic                       slot_re;
  logic [AW-1:0]              slot_ra;
  logic                       slot_we;
  logic [AW-1:0]              slot_wa;

  logic [BW-1:0] mod_step_rem;
  logic [FW-1:0] fill_lim;
  logic          scan_issue;

  assign in_ready        = (state_r == ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_bucket_full = out_full_r;

  // Remainder step: shift in MOD_DIGIT key bits, reducing after each one.
  always_comb begin
    logic [BW:0]   t;
    logic [BW-1:0] rem;
    rem = rem_r;
    for (int j = 0; j < hsis_pkg::MOD_DIGIT; j++) begin
      t = {rem, mod_sh_r[hsis_pkg::MOD_W-1-j]};
      if (t >= BUCKETS_X) begin
        t = t - BUCKETS_X;
      end
      rem = t[BW-1:0];
    end
    mod_step_rem = rem;
  end

  // Fill count limited to the slot count of a bucket.
  assign fill_lim   = (fill_q_r > SLOTS_F) ? SLOTS_F : fill_q_r;
  assign scan_issue = (scan_idx_r < fill_lim);

  // Sequencer: next state, datapath updates and memory control.
  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    mod_sh_nxt    = mod_sh_r;
    mod_cnt_nxt   = mod_cnt_r;
    rem_nxt       = rem_r;
    base_nxt      = base_r;
    scan_idx_nxt  = scan_idx_r;
    cmp_valid_nxt = 1'b0;
    res_found_nxt = res_found_r;
    res_full_nxt  = res_full_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_found_nxt = out_found_r;
    out_full_nxt  = out_full_r;
    fill_re       = 1'b0;
    fill_we       = 1'b0;
    fill_wa       = rem_r;
    fill_wd       = fill_q_r + FW'(1);
    slot_re       = 1'b0;
    slot_ra       = base_r + AW'(scan_idx_r);
    slot_we       = 1'b0;
    slot_wa       = base_r + AW'(fill_q_r);

    unique case (state_r)
      // Zero the fill count of every bucket after reset.
      ST_CLEAR: begin
        fill_we = 1'b1;
        fill_wa = clr_cnt_r;
        fill_wd = '0;
        clr_cnt_nxt = clr_cnt_r + BW'(1);
        if (clr_cnt_r == LAST_BKT) begin
          state_nxt = ST_IDLE;
        end
      end
      // Take a request.
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt      = in_opcode;
          key_nxt     = in_key_value;
          mod_sh_nxt  = hsis_pkg::MOD_W'(in_key_value);
          mod_cnt_nxt = '0;
          rem_nxt     = '0;
          state_nxt   = ST_MOD;
        end
      end
      // Form the bucket index.
      ST_MOD: begin
        rem_nxt     = mod_step_rem;
        mod_sh_nxt  = mod_sh_r << hsis_pkg::MOD_DIGIT;
        mod_cnt_nxt = mod_cnt_r + hsis_pkg::MOD_CNT_W'(1);
        if (mod_cnt_r == hsis_pkg::MOD_CNT_W'(hsis_pkg::MOD_CYC - 1)) begin
          state_nxt = ST_FILL_RD;
        end
      end
      // Read the bucket's fill count and form its first slot address.
      ST_FILL_RD: begin
        fill_re   = 1'b1;
        base_nxt  = AW'(rem_r) * SLOTS_A;
        state_nxt = ST_DECIDE;
      end
      // Append on insert, or start the slot scan on search.
      ST_DECIDE: begin
        res_found_nxt = 1'b0;
        res_full_nxt  = 1'b0;
        scan_idx_nxt  = '0;
        if (op_r == hsis_pkg::OP_INSERT) begin
          if (fill_q_r >= SLOTS_F) begin
            res_full_nxt = 1'b1;
          end else begin
            slot_we = 1'b1;
            fill_we = 1'b1;
          end
          state_nxt = ST_RESULT;
        end else if (fill_lim == '0) begin
          state_nxt = ST_RESULT;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      // Read one slot per cycle; compare the slot read in the cycle before.
      ST_SCAN: begin
        if (scan_issue) begin
          slot_re       = 1'b1;
          scan_idx_nxt  = scan_idx_r + FW'(1);
          cmp_valid_nxt = 1'b1;
        end
        if (cmp_valid_r && (slot_q_r == key_r)) begin
          res_found_nxt = 1'b1;
          cmp_valid_nxt = 1'b0;
          state_nxt     = ST_RESULT;
        end else if (!scan_issue) begin
          state_nxt = ST_RESULT;
        end
      end
      // Hand the result to the output register once it is free.
      ST_RESULT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = res_found_r;
          out_full_nxt  = res_full_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      mod_cnt_r   <= '0;
      cmp_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      op_r        <= op_nxt;
      key_r       <= key_nxt;
      mod_sh_r    <= mod_sh_nxt;
      mod_cnt_r   <= mod_cnt_nxt;
      rem_r       <= rem_nxt;
      base_r      <= base_nxt;
      scan_idx_r  <= scan_idx_nxt;
      cmp_valid_r <= cmp_valid_nxt;
      res_found_r <= res_found_nxt;
      res_full_r  <= res_full_nxt;
      out_valid_r <= out_valid_nxt;
      out_found_r <= out_found_nxt;
      out_full_r  <= out_full_nxt;
    end
  end

  // Fill count memory.
  always_ff @(posedge clk) begin
    if (fill_we) begin
      fill_mem[fill_wa] <= fill_wd;
    end
    if (fill_re) begin
      fill_q_r <= fill_mem[rem_r];
    end
  end

  // Slot key memory.
  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_wa] <= key_r;
    end
    if (slot_re) begin
      slot_q_r <= slot_mem[slot_ra];
    end
  end

endmodule
